>>> rtl/keqf_pkg.sv
// Shared types, constants and helper functions for the k-mer extraction block.
// Used by keqf_regs, keqf_window and kmer_extract_quality_filter; depends on nothing.

package keqf_pkg;

  localparam int MAX_KMER = 32;
  localparam int KEY_W    = 2 * MAX_KMER;
  localparam int START_W  = 16;
  localparam int LEN_W    = 6;
  localparam int QUAL_W   = 7;
  localparam int CHAR_W   = 8;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int SHIFT_W  = 7;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [QUAL_W-1:0]  qual_t;
  typedef logic [CHAR_W-1:0]  char_t;
  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [START_W-1:0] count_t;
  typedef logic [1:0]         code_t;

  localparam count_t COUNT_MAX   = '1;
  localparam len_t   KMER_RESET  = 6'd16;
  localparam len_t   KMER_MAX    = 6'(MAX_KMER);

  localparam char_t CHAR_C = 8'h43;
  localparam char_t CHAR_G = 8'h47;
  localparam char_t CHAR_T = 8'h54;

  localparam code_t CODE_A = 2'd0;
  localparam code_t CODE_C = 2'd1;
  localparam code_t CODE_G = 2'd2;
  localparam code_t CODE_T = 2'd3;

  typedef enum logic [1:0] {
    REG_KMER_LENGTH       = 2'd0,
    REG_QUALITY_THRESHOLD = 2'd1,
    REG_FILTER_ENABLE     = 2'd2
  } reg_idx_t;

  typedef struct packed {
    len_t  kmer_length;
    qual_t quality_threshold;
    logic  filter_enable;
  } cfg_t;

  typedef struct packed {
    logic   hit;
    key_t   key;
    count_t start;
  } res_t;

  // Letters other than upper-case C, G and T code as A.
  function automatic code_t base_code(input char_t c);
    code_t r;
    case (c)
      CHAR_C:  r = CODE_C;
      CHAR_G:  r = CODE_G;
      CHAR_T:  r = CODE_T;
      default: r = CODE_A;
    endcase
    return r;
  endfunction

  // A length of zero acts as one, anything above the maximum as the maximum.
  function automatic len_t active_length(input len_t k);
    len_t r;
    if (k == '0) begin
      r = 6'd1;
    end else if (k > KMER_MAX) begin
      r = KMER_MAX;
    end else begin
      r = k;
    end
    return r;
  endfunction

endpackage

>>> rtl/keqf_regs.sv
// Configuration registers behind the APB-style port of the k-mer block.
// Depends on keqf_pkg for the register indexes and the configuration struct.

module keqf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [keqf_pkg::ADDR_W-1:0] paddr,
  input  logic [keqf_pkg::DATA_W-1:0] pwdata,
  output logic [keqf_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output keqf_pkg::cfg_t              cfg
);

  keqf_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = keqf_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kmer_length       <= keqf_pkg::KMER_RESET;
      cfg.quality_threshold <= '0;
      cfg.filter_enable     <= 1'b0;
    end else if (wr) begin
      unique case (idx)
        keqf_pkg::REG_KMER_LENGTH:       cfg.kmer_length       <= pwdata[keqf_pkg::LEN_W-1:0];
        keqf_pkg::REG_QUALITY_THRESHOLD: cfg.quality_threshold <= pwdata[keqf_pkg::QUAL_W-1:0];
        keqf_pkg::REG_FILTER_ENABLE:     cfg.filter_enable     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      keqf_pkg::REG_KMER_LENGTH:
        prdata = {{(keqf_pkg::DATA_W-keqf_pkg::LEN_W){1'b0}}, cfg.kmer_length};
      keqf_pkg::REG_QUALITY_THRESHOLD:
        prdata = {{(keqf_pkg::DATA_W-keqf_pkg::QUAL_W){1'b0}}, cfg.quality_threshold};
      keqf_pkg::REG_FILTER_ENABLE:
        prdata = {{(keqf_pkg::DATA_W-1){1'b0}}, cfg.filter_enable};
      default: prdata = '0;
    endcase
  end

  a_len_write: assert property (@(posedge clk) disable iff (rst)
    wr && idx == keqf_pkg::REG_KMER_LENGTH |=>
      cfg.kmer_length == $past(pwdata[keqf_pkg::LEN_W-1:0]))
    else $error("kmer_length write not taken");

endmodule

>>> rtl/keqf_window.sv
// Sliding base and quality windows, read position counter and the k-mer decision.
// Depends on keqf_pkg; the result is combinational from the state and the incoming base.

module keqf_window (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        step,
  input  logic [keqf_pkg::CHAR_W-1:0] base_char,
  input  logic [keqf_pkg::QUAL_W-1:0] base_quality,
  input  logic                        read_end,
  input  keqf_pkg::cfg_t              cfg,
  output keqf_pkg::res_t              res
);

  keqf_pkg::key_t   base_window;
  keqf_pkg::key_t   base_window_next;
  keqf_pkg::qual_t  quality_window      [keqf_pkg::MAX_KMER];
  keqf_pkg::qual_t  quality_window_next [keqf_pkg::MAX_KMER];
  keqf_pkg::count_t bases_seen;
  keqf_pkg::count_t bases_seen_next;
  keqf_pkg::len_t   k;
  logic [keqf_pkg::MAX_KMER-1:0]  qual_ok;
  logic [keqf_pkg::SHIFT_W-1:0]   key_shift;
  logic                           full;

  assign k = keqf_pkg::active_length(cfg.kmer_length);

  // The newest base enters at the top; the oldest drops off the bottom.
  assign base_window_next = {keqf_pkg::base_code(base_char),
                             base_window[keqf_pkg::KEY_W-1:2]};

  always_comb begin
    quality_window_next[0] = base_quality;
    for (int i = 1; i < keqf_pkg::MAX_KMER; i++) begin
      quality_window_next[i] = quality_window[i-1];
    end
  end

  assign bases_seen_next = (bases_seen != keqf_pkg::COUNT_MAX) ?
                           bases_seen + 16'd1 : bases_seen;

  // The minimum exceeds the threshold exactly when every quality in the window does.
  always_comb begin
    for (int i = 0; i < keqf_pkg::MAX_KMER; i++) begin
      qual_ok[i] = (keqf_pkg::LEN_W'(i) >= k) ||
                   (quality_window_next[i] > cfg.quality_threshold);
    end
  end

  assign full      = bases_seen_next >= {{(keqf_pkg::START_W-keqf_pkg::LEN_W){1'b0}}, k};
  assign key_shift = keqf_pkg::SHIFT_W'(keqf_pkg::KEY_W) - {1'b0, k[keqf_pkg::LEN_W-2:0], 1'b0}
                     - {k[keqf_pkg::LEN_W-1], {(keqf_pkg::SHIFT_W-1){1'b0}}};

  always_comb begin
    res.hit   = full && (!cfg.filter_enable || (&qual_ok));
    res.key   = base_window_next >> key_shift;
    res.start = (bases_seen_next == keqf_pkg::COUNT_MAX) ? keqf_pkg::COUNT_MAX :
                bases_seen_next - {{(keqf_pkg::START_W-keqf_pkg::LEN_W){1'b0}}, k};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_window <= '0;
      bases_seen  <= '0;
    end else if (step) begin
      if (read_end) begin
        base_window <= '0;
        bases_seen  <= '0;
      end else begin
        base_window <= base_window_next;
        bases_seen  <= bases_seen_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      quality_window <= quality_window_next;
    end
  end

  a_read_restart: assert property (@(posedge clk) disable iff (rst)
    step && read_end |=> bases_seen == '0 && base_window == '0)
    else $error("window not cleared at end of read");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    step && !read_end && bases_seen != keqf_pkg::COUNT_MAX |=>
      bases_seen == $past(bases_seen) + 16'd1)
    else $error("base counter did not advance");

endmodule

>>> rtl/kmer_extract_quality_filter.sv
// Top level of the k-mer extraction block with quality filter.
// Depends on keqf_pkg, keqf_regs (configuration) and keqf_window (datapath).
//
//   channel  | handshake           | payload
//   ---------+---------------------+-----------------------------------------
//   input    | in_valid / in_ready | base_char, base_quality, read_end
//   output   | out_valid/out_ready | kmer_key, kmer_start
//   config   | psel/penable/pready | pwrite, paddr, pwdata, prdata
//
// One base is taken per cycle while the output does not stall; its k-mer, if any,
// appears on the output register in the following cycle.
// The single output register sets the rate: a new base is taken whenever the
// register is empty or its contents are transferred in the same cycle.
// A stall on the output holds the register and lowers in_ready until the transfer.
// Synchronous reset clears the base window, the counter and the output valid flag and
// restores kmer_length to 16; no clearing pass is needed.

module kmer_extract_quality_filter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [keqf_pkg::CHAR_W-1:0]  base_char,
  input  logic [keqf_pkg::QUAL_W-1:0]  base_quality,
  input  logic                         read_end,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [keqf_pkg::KEY_W-1:0]   kmer_key,
  output logic [keqf_pkg::START_W-1:0] kmer_start,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [keqf_pkg::ADDR_W-1:0]  paddr,
  input  logic [keqf_pkg::DATA_W-1:0]  pwdata,
  output logic [keqf_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  keqf_pkg::cfg_t cfg;
  keqf_pkg::res_t res;
  logic           in_accept;

  keqf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The window advances on every accepted base, whether or not it yields a k-mer.
  keqf_window u_window (
    .clk          (clk),
    .rst          (rst),
    .step         (in_accept),
    .base_char    (base_char),
    .base_quality (base_quality),
    .read_end     (read_end),
    .cfg          (cfg),
    .res          (res)
  );

  // The output register is free when empty or when its result is transferred now.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= res.hit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The payload needs no reset: it is only looked at while out_valid is high.
  always_ff @(posedge clk) begin
    if (in_accept && res.hit) begin
      kmer_key   <= res.key;
      kmer_start <= res.start;
    end
  end

  a_no_hit_empty: assert property (@(posedge clk) disable iff (rst)
    in_accept && !res.hit |=> !out_valid)
    else $error("result shown for a base that yields no k-mer");

  a_key_upper_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (kmer_key >> {keqf_pkg::active_length(cfg.kmer_length), 1'b0}) == '0)
    else $error("k-mer key has bits above its length");

endmodule
